>>> hw/rtl/csbm_pkg.sv
// Shared types and constants for the cosine spectrum best-match block.
// Used by csbm_mul, csbm_sub and the cosine_spectrum_best_match top level.
package csbm_pkg;

  localparam int LibrarySize = 16;
  localparam int SampleW     = 16;
  localparam int ThreshW     = 15;
  localparam int IdxW        = 4;
  localparam int SimW        = 16;
  localparam int DotW        = 40;
  localparam int EnergyW     = 38;
  localparam int MulOpW      = 33;
  localparam int WideW       = 64;
  localparam int RootW       = 31;
  localparam int RemW        = 33;
  localparam int QuotW       = 15;

  localparam logic [ThreshW-1:0] ThreshReset = 15'd29491;

  // reference index saturates here
  localparam logic [IdxW-1:0] IdxLimit =
    (LibrarySize - 1 > 15) ? 4'd15 : IdxW'(LibrarySize - 1);

  localparam logic [4:0] SqrtLastIter = 5'd30;
  localparam logic [4:0] DivLastIter  = 5'd14;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_MDOT = 12'b0000_0000_0010,
    S_MEM  = 12'b0000_0000_0100,
    S_MER  = 12'b0000_0000_1000,
    S_AER  = 12'b0000_0001_0000,
    S_CHK  = 12'b0000_0010_0000,
    S_SQA  = 12'b0000_0100_0000,
    S_SQB  = 12'b0000_1000_0000,
    S_MULD = 12'b0001_0000_0000,
    S_DCHK = 12'b0010_0000_0000,
    S_DIV  = 12'b0100_0000_0000,
    S_RES  = 12'b1000_0000_0000
  } state_e;

endpackage

>>> hw/rtl/csbm_mul.sv
// Shared signed multiplier with registered product.
// Depends on csbm_pkg for operand and product widths.
module csbm_mul (
  input  logic                                clk_i,
  input  logic signed [csbm_pkg::MulOpW-1:0] a_i,
  input  logic signed [csbm_pkg::MulOpW-1:0] b_i,
  output logic        [csbm_pkg::WideW-1:0]  p_o
);

  logic signed [2*csbm_pkg::MulOpW-1:0] prod;
  logic        [csbm_pkg::WideW-1:0]    p_q;

  assign prod = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= prod[csbm_pkg::WideW-1:0];
  end

  assign p_o = p_q;

endmodule

>>> hw/rtl/csbm_sub.sv
// Shared 64-bit compare and subtract step for square root and division.
// Depends on csbm_pkg for the word width.
module csbm_sub (
  input  logic [csbm_pkg::WideW-1:0] a_i,
  input  logic [csbm_pkg::WideW-1:0] b_i,
  output logic [csbm_pkg::WideW-1:0] diff_o,
  output logic                       ge_o
);

  logic [csbm_pkg::WideW:0] full;

  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[csbm_pkg::WideW-1:0];
  assign ge_o   = ~full[csbm_pkg::WideW];

endmodule

>>> hw/rtl/cosine_spectrum_best_match.sv
// Cosine-similarity best match over a streamed library of reference spectra. Every
// beat carries one measured and one reference point (signed Q3.12); the block takes
// one beat, then runs S_MDOT, S_MEM, S_MER and S_AER on the shared multiplier to build
// the dot product and both energies. A point marked last_point adds the similarity: a
// check, two 31-step square roots on the shared 64-bit subtractor, a multiply of the
// two roots, a compare and up to 15 divide steps on the subtractor, and a result state;
// an energy or dot product of zero goes straight to the result. in_stall_o stays high
// during that work. The result beat sits in an output register, so the next point is
// taken while it waits. The closing reference (last_point with last_reference) also
// carries the best index, its confidence and match_found (best strictly above the match
// limit), then the search state clears. The user writes the match limit through the
// cfg channel while idle; the block itself does not enforce this.
// Depends on csbm_pkg, csbm_mul and csbm_sub.
module cosine_spectrum_best_match (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [csbm_pkg::ThreshW-1:0]          match_limit_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [csbm_pkg::SampleW-1:0]   measured_sample_i,
  input  logic signed [csbm_pkg::SampleW-1:0]   reference_sample_i,
  input  logic                                  last_point_i,
  input  logic                                  last_reference_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [csbm_pkg::IdxW-1:0]             reference_index_o,
  output logic signed [csbm_pkg::SimW-1:0]      similarity_o,
  output logic                                  search_done_o,
  output logic [csbm_pkg::IdxW-1:0]             best_index_o,
  output logic [csbm_pkg::ThreshW-1:0]          best_confidence_o,
  output logic                                  match_found_o
);

  localparam int DotW    = csbm_pkg::DotW;
  localparam int EnergyW = csbm_pkg::EnergyW;
  localparam int WideW   = csbm_pkg::WideW;
  localparam int RootW   = csbm_pkg::RootW;
  localparam int RemW    = csbm_pkg::RemW;
  localparam int QuotW   = csbm_pkg::QuotW;
  localparam int MulOpW  = csbm_pkg::MulOpW;
  localparam int SampleW = csbm_pkg::SampleW;
  localparam int IdxW    = csbm_pkg::IdxW;
  localparam int ThreshW = csbm_pkg::ThreshW;
  localparam int SimW    = csbm_pkg::SimW;
  localparam int XW      = 2 * RootW;

  csbm_pkg::state_e state_q, state_d;

  logic [ThreshW-1:0]        thr_q;
  logic signed [SampleW-1:0] m_q, rs_q;
  logic                      last_pt_q, last_ref_q;
  logic signed [DotW-1:0]    dot_q, dot_d;
  logic [EnergyW-1:0]        em_q, em_d, er_q, er_d;
  logic [DotW-1:0]           mag_q, mag_d;
  logic [XW-1:0]             x_q, x_d;
  logic [RemW-1:0]           rem_q, rem_d;
  logic [RootW-1:0]          root_q, root_d, sa_q, sa_d;
  logic [4:0]                it_q, it_d;
  logic [WideW-1:0]          r_q, r_d, den_q, den_d;
  logic [QuotW:0]            quo_q, quo_d;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic [ThreshW-1:0]        best_q, best_d;
  logic [IdxW-1:0]           best_idx_q, best_idx_d;
  logic                      best_vld_q, best_vld_d;

  logic                      out_valid_q, out_valid_d;
  logic [IdxW-1:0]           o_idx_q;
  logic signed [SimW-1:0]    o_sim_q;
  logic                      o_done_q;
  logic [IdxW-1:0]           o_bidx_q;
  logic [ThreshW-1:0]        o_conf_q;
  logic                      o_match_q;

  logic signed [MulOpW-1:0]  mul_a, mul_b;
  logic [WideW-1:0]          prod;
  logic [WideW-1:0]          sub_a, sub_b, sub_diff;
  logic                      sub_ge;

  logic                      in_fire, res_fire;
  logic signed [DotW:0]      dot_sum;
  logic [EnergyW:0]          em_sum, er_sum;
  logic [RemW+1:0]           rem_sh;
  logic signed [SimW-1:0]    sim;
  logic                      upd;
  logic [ThreshW-1:0]        nb_sim;
  logic [IdxW-1:0]           nb_idx;
  logic                      nb_vld;

  csbm_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  csbm_sub u_sub (
    .a_i    (sub_a),
    .b_i    (sub_b),
    .diff_o (sub_diff),
    .ge_o   (sub_ge)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != csbm_pkg::S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign res_fire    = (state_q == csbm_pkg::S_RES) && (!out_valid_q || !out_stall_i);

  // multiplier operand select
  always_comb begin
    mul_a = MulOpW'(m_q);
    mul_b = MulOpW'(rs_q);
    case (state_q)
      csbm_pkg::S_MEM: begin
        mul_a = MulOpW'(m_q);
        mul_b = MulOpW'(m_q);
      end
      csbm_pkg::S_MER: begin
        mul_a = MulOpW'(rs_q);
        mul_b = MulOpW'(rs_q);
      end
      csbm_pkg::S_MULD: begin
        mul_a = $signed({2'b00, sa_q});
        mul_b = $signed({2'b00, root_q});
      end
      default: begin
        mul_a = MulOpW'(m_q);
        mul_b = MulOpW'(rs_q);
      end
    endcase
  end

  // subtractor operand select
  assign rem_sh = {rem_q, x_q[XW-1 -: 2]};

  always_comb begin
    sub_a = WideW'(rem_sh);
    sub_b = WideW'({root_q, 2'b01});
    case (state_q)
      csbm_pkg::S_DCHK: begin
        sub_a = {mag_q, 24'd0};
        sub_b = prod;
      end
      csbm_pkg::S_DIV: begin
        sub_a = {r_q[WideW-2:0], 1'b0};
        sub_b = den_q;
      end
      default: begin
        sub_a = WideW'(rem_sh);
        sub_b = WideW'({root_q, 2'b01});
      end
    endcase
  end

  // saturating accumulators
  assign dot_sum = {dot_q[DotW-1], dot_q} + (DotW+1)'($signed(prod[31:0]));
  assign em_sum  = {1'b0, em_q} + (EnergyW+1)'(prod[31:0]);
  assign er_sum  = {1'b0, er_q} + (EnergyW+1)'(prod[31:0]);

  // final similarity and best tracking
  always_comb begin
    if (dot_q[DotW-1]) begin
      sim = SimW'(-$signed({1'b0, quo_q}));
    end else if (quo_q[QuotW]) begin
      sim = 16'sh7FFF;
    end else begin
      sim = $signed(quo_q);
    end
    upd    = !sim[SimW-1] && (sim[ThreshW-1:0] > best_q);
    nb_sim = upd ? sim[ThreshW-1:0] : best_q;
    nb_idx = upd ? idx_q : best_idx_q;
    nb_vld = upd || best_vld_q;
  end

  always_comb begin
    state_d    = state_q;
    dot_d      = dot_q;
    em_d       = em_q;
    er_d       = er_q;
    mag_d      = mag_q;
    x_d        = x_q;
    rem_d      = rem_q;
    root_d     = root_q;
    sa_d       = sa_q;
    it_d       = it_q;
    r_d        = r_q;
    den_d      = den_q;
    quo_d      = quo_q;
    idx_d      = idx_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    best_vld_d = best_vld_q;

    case (state_q)
      csbm_pkg::S_IDLE: begin
        if (in_fire) begin
          state_d = csbm_pkg::S_MDOT;
        end
      end
      csbm_pkg::S_MDOT: begin
        state_d = csbm_pkg::S_MEM;
      end
      csbm_pkg::S_MEM: begin
        if (dot_sum[DotW] != dot_sum[DotW-1]) begin
          dot_d = dot_sum[DotW] ? {1'b1, {(DotW-1){1'b0}}} : {1'b0, {(DotW-1){1'b1}}};
        end else begin
          dot_d = dot_sum[DotW-1:0];
        end
        state_d = csbm_pkg::S_MER;
      end
      csbm_pkg::S_MER: begin
        em_d    = em_sum[EnergyW] ? {EnergyW{1'b1}} : em_sum[EnergyW-1:0];
        state_d = csbm_pkg::S_AER;
      end
      csbm_pkg::S_AER: begin
        er_d    = er_sum[EnergyW] ? {EnergyW{1'b1}} : er_sum[EnergyW-1:0];
        state_d = last_pt_q ? csbm_pkg::S_CHK : csbm_pkg::S_IDLE;
      end
      csbm_pkg::S_CHK: begin
        mag_d = dot_q[DotW-1] ? DotW'(-dot_q) : DotW'(dot_q);
        if (em_q == '0 || er_q == '0 || dot_q == '0) begin
          quo_d   = '0;
          state_d = csbm_pkg::S_RES;
        end else begin
          x_d     = {em_q, 24'd0};
          rem_d   = '0;
          root_d  = '0;
          it_d    = csbm_pkg::SqrtLastIter;
          state_d = csbm_pkg::S_SQA;
        end
      end
      csbm_pkg::S_SQA, csbm_pkg::S_SQB: begin
        x_d = {x_q[XW-3:0], 2'b00};
        if (sub_ge) begin
          rem_d  = sub_diff[RemW-1:0];
          root_d = {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh[RemW-1:0];
          root_d = {root_q[RootW-2:0], 1'b0};
        end
        it_d = it_q - 5'd1;
        if (it_q == '0) begin
          if (state_q == csbm_pkg::S_SQA) begin
            sa_d    = root_d;
            x_d     = {er_q, 24'd0};
            rem_d   = '0;
            root_d  = '0;
            it_d    = csbm_pkg::SqrtLastIter;
            state_d = csbm_pkg::S_SQB;
          end else begin
            state_d = csbm_pkg::S_MULD;
          end
        end
      end
      csbm_pkg::S_MULD: begin
        state_d = csbm_pkg::S_DCHK;
      end
      csbm_pkg::S_DCHK: begin
        // |dot| * 2^24 >= den means the quotient saturates at 32768
        if (sub_ge) begin
          quo_d   = {1'b1, {QuotW{1'b0}}};
          state_d = csbm_pkg::S_RES;
        end else begin
          r_d     = {mag_q, 24'd0};
          den_d   = prod;
          quo_d   = '0;
          it_d    = csbm_pkg::DivLastIter;
          state_d = csbm_pkg::S_DIV;
        end
      end
      csbm_pkg::S_DIV: begin
        r_d   = sub_ge ? sub_diff : {r_q[WideW-2:0], 1'b0};
        quo_d = {quo_q[QuotW-1:0], sub_ge};
        it_d  = it_q - 5'd1;
        if (it_q == '0) begin
          state_d = csbm_pkg::S_RES;
        end
      end
      csbm_pkg::S_RES: begin
        if (res_fire) begin
          dot_d = '0;
          em_d  = '0;
          er_d  = '0;
          if (last_ref_q) begin
            idx_d      = '0;
            best_d     = '0;
            best_idx_d = '0;
            best_vld_d = 1'b0;
          end else begin
            best_d     = nb_sim;
            best_idx_d = nb_idx;
            best_vld_d = nb_vld;
            if (idx_q < csbm_pkg::IdxLimit) begin
              idx_d = idx_q + 4'd1;
            end
          end
          state_d = csbm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = csbm_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_d = res_fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csbm_pkg::S_IDLE;
      thr_q       <= csbm_pkg::ThreshReset;
      dot_q       <= '0;
      em_q        <= '0;
      er_q        <= '0;
      idx_q       <= '0;
      best_q      <= '0;
      best_idx_q  <= '0;
      best_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dot_q       <= dot_d;
      em_q        <= em_d;
      er_q        <= er_d;
      idx_q       <= idx_d;
      best_q      <= best_d;
      best_idx_q  <= best_idx_d;
      best_vld_q  <= best_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= match_limit_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      m_q        <= measured_sample_i;
      rs_q       <= reference_sample_i;
      last_pt_q  <= last_point_i;
      last_ref_q <= last_reference_i;
    end
    mag_q  <= mag_d;
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    sa_q   <= sa_d;
    it_q   <= it_d;
    r_q    <= r_d;
    den_q  <= den_d;
    quo_q  <= quo_d;
    if (res_fire) begin
      o_idx_q   <= idx_q;
      o_sim_q   <= sim;
      o_done_q  <= last_ref_q;
      o_bidx_q  <= (last_ref_q && nb_vld) ? nb_idx : '0;
      o_conf_q  <= last_ref_q ? nb_sim : '0;
      o_match_q <= last_ref_q && nb_vld && (nb_sim > thr_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign reference_index_o = o_idx_q;
  assign similarity_o      = o_sim_q;
  assign search_done_o     = o_done_q;
  assign best_index_o      = o_bidx_q;
  assign best_confidence_o = o_conf_q;
  assign match_found_o     = o_match_q;

`ifndef NO_ASSERTIONS
  a_accept_starts_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == csbm_pkg::S_MDOT)
    else $error("accepted beat did not start the multiply sequence");

  a_zero_energy_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == csbm_pkg::S_CHK && (em_q == '0 || er_q == '0))
      |=> state_q == csbm_pkg::S_RES && quo_q == '0)
    else $error("zero energy did not give a zero similarity");

  a_match_only_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && match_found_o) |-> search_done_o)
    else $error("match reported on a result that does not close the search");

  a_no_best_zero_conf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !best_vld_q |-> (best_q == '0 && best_idx_q == '0))
    else $error("best similarity held without a best reference");
`endif

endmodule

>>> sim/tb_cosine_spectrum_best_match.sv
// Self-checking testbench for cosine_spectrum_best_match: a scoreboard class predicts every
// similarity beat and search summary, tasks drive points and cfg writes, stalls are random.
// Depends on csbm_pkg and the cosine_spectrum_best_match RTL.

typedef struct {
  logic [csbm_pkg::IdxW-1:0]        ref_index;
  logic signed [csbm_pkg::SimW-1:0] similarity;
  logic                             search_done;
  logic [csbm_pkg::IdxW-1:0]        best_index;
  logic [csbm_pkg::ThreshW-1:0]     best_confidence;
  logic                             match_found;
} match_result_t;

class match_scoreboard;
  longint dot_hi    = (longint'(1) <<< (csbm_pkg::DotW - 1)) - 1;
  longint dot_lo    = -(longint'(1) <<< (csbm_pkg::DotW - 1));
  longint energy_hi = (longint'(1) <<< csbm_pkg::EnergyW) - 1;

  longint                       dot_sum;
  longint                       meas_energy;
  longint                       ref_energy;
  logic [csbm_pkg::IdxW-1:0]    ref_count;
  logic [csbm_pkg::IdxW-1:0]    best_ref;
  int                           best_sim;
  bit                           have_best;
  logic [csbm_pkg::ThreshW-1:0] threshold;
  match_result_t                expected_results[$];
  int                           errors;

  function new();
    threshold   = csbm_pkg::ThreshReset;
    dot_sum     = 0;
    meas_energy = 0;
    ref_energy  = 0;
    ref_count   = '0;
    best_ref    = '0;
    best_sim    = 0;
    have_best   = 1'b0;
    errors      = 0;
  endfunction

  function longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  // dot is Q6.24, sqrt(E * 2^24) is Q.24 each, so the scale to Q1.15 is 2^39
  function int cosine_q15(longint dot, longint unsigned em, longint unsigned er);
    logic [127:0]    num;
    logic [127:0]    den;
    logic [127:0]    quo;
    longint unsigned mag;
    if (em == 0 || er == 0 || dot == 0) return 0;
    mag = (dot < 0) ? -dot : dot;
    num = 128'(mag) << 39;
    den = 128'(floor_sqrt(em << 24)) * 128'(floor_sqrt(er << 24));
    quo = num / den;
    if (quo > 128'd32768) quo = 128'd32768;
    if (dot < 0) return -int'(quo);
    return (quo > 128'd32767) ? 32767 : int'(quo);
  endfunction

  function void absorb_point(logic signed [csbm_pkg::SampleW-1:0] meas,
                             logic signed [csbm_pkg::SampleW-1:0] refr,
                             logic last_pt, logic last_ref);
    longint        sum;
    int            sim;
    match_result_t res;
    sum = dot_sum + longint'(meas) * longint'(refr);
    dot_sum = (sum > dot_hi) ? dot_hi : ((sum < dot_lo) ? dot_lo : sum);
    sum = meas_energy + longint'(meas) * longint'(meas);
    meas_energy = (sum > energy_hi) ? energy_hi : sum;
    sum = ref_energy + longint'(refr) * longint'(refr);
    ref_energy = (sum > energy_hi) ? energy_hi : sum;
    if (!last_pt) return;

    sim = cosine_q15(dot_sum, meas_energy, ref_energy);
    dot_sum     = 0;
    meas_energy = 0;
    ref_energy  = 0;
    // strict compare: earliest reference keeps a tie
    if (sim > best_sim) begin
      best_sim  = sim;
      best_ref  = ref_count;
      have_best = 1'b1;
    end

    res.ref_index       = ref_count;
    res.similarity      = 16'(sim);
    res.search_done     = last_ref;
    res.best_index      = '0;
    res.best_confidence = '0;
    res.match_found     = 1'b0;
    if (last_ref) begin
      if (have_best) res.best_index = best_ref;
      res.best_confidence = 15'(best_sim);
      res.match_found     = have_best && (best_sim > int'(threshold));
      ref_count = '0;
      best_ref  = '0;
      best_sim  = 0;
      have_best = 1'b0;
    end else if (ref_count < csbm_pkg::IdxLimit) begin
      ref_count++;
    end
    expected_results.push_back(res);
  endfunction

  function void report_field(string field, logic signed [63:0] want,
                             logic signed [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  function void check_result(match_result_t got);
    match_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result beat, reference_index %0d similarity %0d",
               $time, got.ref_index, got.similarity);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    report_field("reference_index", want.ref_index, got.ref_index);
    report_field("similarity", want.similarity, got.similarity);
    report_field("search_done", want.search_done, got.search_done);
    report_field("best_index", want.best_index, got.best_index);
    report_field("best_confidence", want.best_confidence, got.best_confidence);
    report_field("match_found", want.match_found, got.match_found);
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module tb_cosine_spectrum_best_match;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles   = 100;
  localparam int PhaseItems    = 110;
  localparam int SaturateRun   = 520;

  typedef enum int {
    STYLE_RANDOM,
    STYLE_ALIGNED,
    STYLE_SCALED,
    STYLE_OPPOSED,
    STYLE_TINY,
    STYLE_SILENT,
    STYLE_EXTREME,
    STYLE_SAT_POS,
    STYLE_SAT_NEG
  } point_style_e;

  localparam int RandomStyles = STYLE_EXTREME + 1;

  typedef struct {
    logic signed [csbm_pkg::SampleW-1:0] meas;
    logic signed [csbm_pkg::SampleW-1:0] refr;
    logic                                last_pt;
    logic                                last_ref;
  } point_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic [csbm_pkg::ThreshW-1:0]        match_limit_i;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic signed [csbm_pkg::SampleW-1:0] measured_sample_i;
  logic signed [csbm_pkg::SampleW-1:0] reference_sample_i;
  logic                                last_point_i;
  logic                                last_reference_i;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic [csbm_pkg::IdxW-1:0]           reference_index_o;
  logic signed [csbm_pkg::SimW-1:0]    similarity_o;
  logic                                search_done_o;
  logic [csbm_pkg::IdxW-1:0]           best_index_o;
  logic [csbm_pkg::ThreshW-1:0]        best_confidence_o;
  logic                                match_found_o;

  match_scoreboard sb;
  point_t          plan[$];
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              watchdog = 0;

  cosine_spectrum_best_match dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .match_limit_i      (match_limit_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .measured_sample_i  (measured_sample_i),
    .reference_sample_i (reference_sample_i),
    .last_point_i       (last_point_i),
    .last_reference_i   (last_reference_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .reference_index_o  (reference_index_o),
    .similarity_o       (similarity_o),
    .search_done_o      (search_done_o),
    .best_index_o       (best_index_o),
    .best_confidence_o  (best_confidence_o),
    .match_found_o      (match_found_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    match_result_t got;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && !out_stall_i) begin
      got.ref_index       = reference_index_o;
      got.similarity      = similarity_o;
      got.search_done     = search_done_o;
      got.best_index      = best_index_o;
      got.best_confidence = best_confidence_o;
      got.match_found     = match_found_o;
      sb.check_result(got);
    end
  end

  // counts cycles in which no beat moves on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      watchdog = 0;
    end else begin
      watchdog++;
    end
    if (watchdog >= WatchdogLimit) begin
      $display("[cosine_spectrum_best_match] ERROR");
      $finish;
    end
  end

  function automatic logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic point_t make_point(point_style_e style);
    point_t p;
    int     m;
    int     r;
    m = int'($urandom_range(65535)) - 32768;
    r = int'($urandom_range(65535)) - 32768;
    case (style)
      STYLE_ALIGNED: r = m + int'($urandom_range(512)) - 256;
      STYLE_SCALED:  r = m >>> $urandom_range(3);
      STYLE_OPPOSED: r = -m + int'($urandom_range(512)) - 256;
      STYLE_TINY: begin
        m = int'($urandom_range(8)) - 4;
        r = int'($urandom_range(8)) - 4;
      end
      STYLE_SILENT: begin
        if ($urandom_range(1) == 0) m = 0;
        else r = 0;
      end
      STYLE_EXTREME: begin
        m = ($urandom_range(1) == 0) ? 32767 : -32768;
        r = ($urandom_range(1) == 0) ? 32767 : -32768;
      end
      STYLE_SAT_POS: begin
        m = ($urandom_range(1) == 0) ? 32767 : -32768;
        r = m;
      end
      STYLE_SAT_NEG: begin
        m = ($urandom_range(1) == 0) ? 32767 : -32768;
        r = (m < 0) ? 32767 : -32768;
      end
      default: ;
    endcase
    p.meas     = sat16(m);
    p.refr     = sat16(r);
    p.last_pt  = 1'b0;
    // a stray last_reference on an inner point must be ignored
    p.last_ref = ($urandom_range(7) == 0);
    return p;
  endfunction

  function automatic void add_point(int m, int r, logic last_pt, logic last_ref);
    point_t p;
    p.meas     = sat16(m);
    p.refr     = sat16(r);
    p.last_pt  = last_pt;
    p.last_ref = last_ref;
    plan.push_back(p);
  endfunction

  function automatic void add_reference(point_style_e style, int npts, bit closing);
    point_t p;
    for (int i = 0; i < npts; i++) begin
      p = make_point(style);
      if (i == npts - 1) begin
        p.last_pt  = 1'b1;
        p.last_ref = closing;
      end
      add_point(p.meas, p.refr, p.last_pt, p.last_ref);
    end
  endfunction

  function automatic void add_search(int nrefs, bit short_refs);
    int npts;
    for (int k = 0; k < nrefs; k++) begin
      if (short_refs) npts = $urandom_range(1, 2);
      else if ($urandom_range(24) == 0) npts = $urandom_range(5, 64);
      else npts = $urandom_range(1, 4);
      add_reference(point_style_e'($urandom_range(RandomStyles - 1)), npts, k == nrefs - 1);
    end
  endfunction

  // called and returns at a falling edge
  task automatic send_point(point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i         = 1'b1;
    measured_sample_i  = p.meas;
    reference_sample_i = p.refr;
    last_point_i       = p.last_pt;
    last_reference_i   = p.last_ref;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.absorb_point(p.meas, p.refr, p.last_pt, p.last_ref);
    @(negedge clk_i);
  endtask

  task automatic run_plan();
    while (plan.size() != 0) send_point(plan.pop_front());
    in_valid_i = 1'b0;
  endtask

  task automatic write_threshold(logic [csbm_pkg::ThreshW-1:0] value);
    cfg_valid_i   = 1'b1;
    match_limit_i = value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.threshold = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // a point without a result may still be in flight after the last beat
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin
    logic [csbm_pkg::ThreshW-1:0] thr;
    int                           base;
    sb                 = new();
    rst_ni             = 1'b0;
    cfg_valid_i        = 1'b0;
    match_limit_i      = '0;
    in_valid_i         = 1'b0;
    measured_sample_i  = '0;
    reference_sample_i = '0;
    last_point_i       = 1'b0;
    last_reference_i   = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed search under the reset threshold
    add_point(32767, 32767, 1'b1, 1'b0);    // full positive, clamps to max
    add_point(-32768, 32767, 1'b1, 1'b0);   // full negative
    add_point(0, 1000, 1'b1, 1'b0);         // measured energy zero
    add_point(1000, 0, 1'b1, 1'b0);         // reference energy zero
    add_point(100, 100, 1'b0, 1'b1);        // last_reference alone is ignored
    add_point(100, -100, 1'b1, 1'b0);       // dot cancels to zero
    add_point(-32768, -32768, 1'b1, 1'b0);  // ties the first reference
    add_point(1, 0, 1'b0, 1'b0);
    add_point(0, 1, 1'b1, 1'b0);            // orthogonal
    add_point(3, 4, 1'b0, 1'b0);
    add_point(4, 3, 1'b1, 1'b1);
    // nothing positive: no best
    add_point(5, -5, 1'b1, 1'b0);
    add_point(0, 0, 1'b1, 1'b1);
    run_plan();
    wait_drained();

    // best equal to the threshold is not a match, one above is
    thr = 15'(sb.cosine_q15(24, 25, 25));
    write_threshold(thr);
    add_point(3, 4, 1'b0, 1'b0);
    add_point(4, 3, 1'b1, 1'b1);
    run_plan();
    wait_drained();
    write_threshold(thr - 1'b1);
    add_point(3, 4, 1'b0, 1'b0);
    add_point(4, 3, 1'b1, 1'b1);
    run_plan();
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      case (phase)
        0: thr = '0;
        1: thr = '1;
        3: thr = 15'd16384;
        4: thr = 15'($urandom_range(29000, 32767));
        5: thr = 15'd1;
        6: thr = 15'd32766;
        default: thr = 15'($urandom_range(32767));
      endcase
      write_threshold(thr);
      // long references drive the accumulators into saturation
      if (phase == 0) add_reference(STYLE_SAT_POS, SaturateRun, 1'b1);
      if (phase == 4) add_reference(STYLE_SAT_NEG, SaturateRun, 1'b1);
      base = plan.size();
      if (phase % 4 == 3) add_search($urandom_range(17, 20), 1'b1);
      while (plan.size() < base + PhaseItems) begin
        if ($urandom_range(7) == 0) add_search($urandom_range(16, 20), 1'b1);
        else add_search($urandom_range(1, 5), 1'b0);
      end
      run_plan();
      wait_drained();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[cosine_spectrum_best_match] OK");
    end else begin
      $display("[cosine_spectrum_best_match] ERROR");
    end
    $finish;
  end

endmodule
